[src/cqca_pkg.sv]
// shared types and constants for the convex quad clip area block
// no dependencies
package cqca_pkg;

    localparam int NUM_STAGES   = 4;
    localparam int STAGE_W      = 2;
    localparam int COORD_W      = 32;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int CFG_IDX_W    = 4;
    localparam int NUM_CFG_REGS = 2 * NUM_STAGES;
    localparam int PROD_W       = 68;
    localparam int MAG_W        = 66;
    localparam int DEN_W        = MAG_W + 1;
    localparam int QUO_W        = DIFF_W;
    localparam int NUM_W        = 100;
    localparam int ACC_W        = 64;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      ring_is_hole;
        logic                      ring_last;
        logic                      set_last;
    } in_word_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] ring_area;
        logic [ACC_W-2:0]        total_area;
        logic                    set_done;
    } out_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

endpackage

[src/convex_quad_clip_area_top.sv]
// Clips streamed rings against a convex quadrilateral in four cascaded edge stages and
// gives the clipped shoelace area per ring with a running set total. All multiplications go
// through one shared 34x34 multiplier under a sequencer; s_ready is high only while idle.
// A vertex that every edge keeps without a crossing passes through the two multiplies and
// the subtraction of each side test, the fan step and the unwind back to stage zero; each
// edge crossing adds two waits on the shared divider, one per axis and none when the
// denominator is zero, plus a pass through every later stage the extra vertex reaches,
// and a ring end adds the closing pass over the four stages plus its crossings.
// No clearing pass after reset.
// depends on cqca_pkg and cqca_div
module convex_quad_clip_area_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  cqca_pkg::in_word_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output cqca_pkg::out_word_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cqca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cqca_pkg::COORD_W-1:0]      cfg_data
);
    import cqca_pkg::*;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_PUSH    = 5'd1;
    localparam logic [4:0] ST_SIDE1   = 5'd2;
    localparam logic [4:0] ST_SIDE2   = 5'd3;
    localparam logic [4:0] ST_SIDE3   = 5'd4;
    localparam logic [4:0] ST_P_DEC   = 5'd5;
    localparam logic [4:0] ST_P_EMC   = 5'd6;
    localparam logic [4:0] ST_P_END   = 5'd7;
    localparam logic [4:0] ST_RESUME  = 5'd8;
    localparam logic [4:0] ST_I_DEN   = 5'd9;
    localparam logic [4:0] ST_I_DEN2  = 5'd10;
    localparam logic [4:0] ST_I_M1    = 5'd11;
    localparam logic [4:0] ST_I_M2    = 5'd12;
    localparam logic [4:0] ST_I_M3    = 5'd13;
    localparam logic [4:0] ST_I_DIV   = 5'd14;
    localparam logic [4:0] ST_EMIT    = 5'd15;
    localparam logic [4:0] ST_F1      = 5'd16;
    localparam logic [4:0] ST_F2      = 5'd17;
    localparam logic [4:0] ST_F3      = 5'd18;
    localparam logic [4:0] ST_F4      = 5'd19;
    localparam logic [4:0] ST_C_START = 5'd20;
    localparam logic [4:0] ST_C_DEC   = 5'd21;
    localparam logic [4:0] ST_C_NEXT  = 5'd22;
    localparam logic [4:0] ST_FIN1    = 5'd23;
    localparam logic [4:0] ST_FIN2    = 5'd24;

    localparam logic [1:0] RET_X  = 2'd0;
    localparam logic [1:0] RET_C  = 2'd1;
    localparam logic [1:0] RET_CL = 2'd2;

    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(NUM_STAGES - 1);

    function automatic logic signed [DIFF_W-1:0] dif(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    function automatic logic signed [DIFF_W:0] sx(input logic signed [DIFF_W-1:0] v);
        return {v[DIFF_W-1], v};
    endfunction

    logic [4:0]                state_reg, state_next;
    logic [4:0]                side_ret_reg, side_ret_next;
    logic [STAGE_W-1:0]        cs_reg, cs_next;
    logic signed [COORD_W-1:0] corner_x_reg [NUM_STAGES];
    logic signed [COORD_W-1:0] corner_y_reg [NUM_STAGES];
    logic signed [DIFF_W-1:0]  ex_arr [NUM_STAGES];
    logic signed [DIFF_W-1:0]  ey_arr [NUM_STAGES];
    point_t                    fr_pt_reg [NUM_STAGES];
    point_t                    fr_pt_next [NUM_STAGES];
    logic [1:0]                ret_reg [NUM_STAGES];
    logic [1:0]                ret_next [NUM_STAGES];
    point_t                    first_reg [NUM_STAGES];
    point_t                    first_next [NUM_STAGES];
    point_t                    prev_reg [NUM_STAGES];
    point_t                    prev_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]     fr_in_reg, fr_in_next;
    logic [NUM_STAGES-1:0]     prev_in_reg, prev_in_next;
    logic [NUM_STAGES-1:0]     started_reg, started_next;
    point_t                    spt_reg, spt_next;
    point_t                    ip_reg, ip_next;
    point_t                    ic_reg, ic_next;
    point_t                    ev_reg, ev_next;
    point_t                    anc_reg, anc_next;
    point_t                    fprev_reg, fprev_next;
    logic [1:0]                fan_cnt_reg, fan_cnt_next;
    logic signed [ACC_W-1:0]   ring_acc_reg, ring_acc_next;
    logic signed [ACC_W-1:0]   total_reg, total_next;
    logic signed [ACC_W-1:0]   area_reg, area_next;
    logic signed [PROD_W-1:0]  prod_reg, t1_reg, t1_next, side_reg, side_next;
    logic signed [PROD_W-1:0]  term_reg, term_next;
    logic [MAG_W-1:0]          sp_reg, sp_next, sc_reg, sc_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic                      axis_reg, axis_next;
    logic                      hole_reg, hole_next, rlast_reg, rlast_next;
    logic                      slast_reg, slast_next;
    logic                      m_valid_reg, m_valid_next;
    out_word_t                 m_data_reg, m_data_next;

    logic signed [DIFF_W:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]  side_abs;
    logic [MAG_W-1:0]          side_mag;
    logic                      side_in;
    logic signed [DIFF_W-1:0]  dsel;
    logic [DIFF_W-1:0]         dmag;
    logic signed [COORD_W-1:0] psel;
    logic [DIFF_W:0]           lerp_w;
    logic [COORD_W-1:0]        lerp_res;
    logic [DEN_W-1:0]          den_sum;
    logic signed [ACC_W+4:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_sat;
    logic [ACC_W-1:0]          acc_mag;
    logic signed [ACC_W-1:0]   half;
    logic signed [ACC_W:0]     tsum;
    logic signed [ACC_W-1:0]   tsat;
    logic                      div_start;
    logic [NUM_W-1:0]          div_num;
    div_req_t                  div_req;
    logic                      div_done;
    logic [QUO_W-1:0]          quo;

    always_comb begin
        for (int s = 0; s < NUM_STAGES; s++) begin
            ex_arr[s] = dif(corner_x_reg[STAGE_W'(s + 1)], corner_x_reg[s]);
            ey_arr[s] = dif(corner_y_reg[STAGE_W'(s + 1)], corner_y_reg[s]);
        end
    end

    assign side_in  = ~side_reg[PROD_W-1];
    assign side_abs = side_reg[PROD_W-1] ? -side_reg : side_reg;
    assign side_mag = side_abs[MAG_W-1:0];

    assign dsel     = axis_reg ? dif(ic_reg.y, ip_reg.y) : dif(ic_reg.x, ip_reg.x);
    assign dmag     = dsel[DIFF_W-1] ? (~dsel + 1'b1) : dsel;
    assign psel     = axis_reg ? ip_reg.y : ip_reg.x;
    assign lerp_w   = dsel[DIFF_W-1] ? ({{2{psel[COORD_W-1]}}, psel} - {1'b0, quo})
                                     : ({{2{psel[COORD_W-1]}}, psel} + {1'b0, quo});
    assign lerp_res = lerp_w[COORD_W-1:0];

    assign den_sum  = {1'b0, sp_reg} + {1'b0, sc_reg};

    assign acc_sum  = {{5{ring_acc_reg[ACC_W-1]}}, ring_acc_reg}
                    + {term_reg[PROD_W-1], term_reg};
    assign acc_sat  = (acc_sum[ACC_W+4:ACC_W-1] == '0 || acc_sum[ACC_W+4:ACC_W-1] == '1)
                    ? acc_sum[ACC_W-1:0] : (acc_sum[ACC_W+4] ? ACC_MIN : ACC_MAX);

    assign acc_mag  = ring_acc_reg[ACC_W-1] ? (~ring_acc_reg + 1'b1) : ring_acc_reg;
    assign half     = {1'b0, acc_mag[ACC_W-1:1]};

    assign tsum     = {total_reg[ACC_W-1], total_reg} + {area_reg[ACC_W-1], area_reg};
    assign tsat     = (tsum[ACC_W] == tsum[ACC_W-1]) ? tsum[ACC_W-1:0]
                    : (tsum[ACC_W] ? ACC_MIN : ACC_MAX);

    assign div_num = {{(NUM_W-PROD_W){1'b0}}, t1_reg}
                   + {prod_reg[NUM_W-QUO_W-1:0], {QUO_W{1'b0}}};
    assign div_req = '{start: div_start, num: div_num, den: den_reg};

    always_comb begin
        state_next    = state_reg;
        side_ret_next = side_ret_reg;
        cs_next       = cs_reg;
        fr_pt_next    = fr_pt_reg;
        ret_next      = ret_reg;
        first_next    = first_reg;
        prev_next     = prev_reg;
        fr_in_next    = fr_in_reg;
        prev_in_next  = prev_in_reg;
        started_next  = started_reg;
        spt_next      = spt_reg;
        ip_next       = ip_reg;
        ic_next       = ic_reg;
        ev_next       = ev_reg;
        anc_next      = anc_reg;
        fprev_next    = fprev_reg;
        fan_cnt_next  = fan_cnt_reg;
        ring_acc_next = ring_acc_reg;
        total_next    = total_reg;
        area_next     = area_reg;
        t1_next       = t1_reg;
        side_next     = side_reg;
        term_next     = term_reg;
        sp_next       = sp_reg;
        sc_next       = sc_reg;
        den_next      = den_reg;
        axis_next     = axis_reg;
        hole_next     = hole_reg;
        rlast_next    = rlast_reg;
        slast_next    = slast_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;
        mul_a         = '0;
        mul_b         = '0;
        div_start     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    fr_pt_next[0] = '{x: s_data.vertex_x, y: s_data.vertex_y};
                    hole_next     = s_data.ring_is_hole;
                    rlast_next    = s_data.ring_last;
                    slast_next    = s_data.set_last;
                    cs_next       = '0;
                    state_next    = ST_PUSH;
                end
            end
            ST_PUSH: begin
                spt_next      = fr_pt_reg[cs_reg];
                side_ret_next = ST_P_DEC;
                state_next    = ST_SIDE1;
            end
            ST_SIDE1: begin
                mul_a      = sx(ex_arr[cs_reg]);
                mul_b      = sx(dif(spt_reg.y, corner_y_reg[cs_reg]));
                state_next = ST_SIDE2;
            end
            ST_SIDE2: begin
                t1_next    = prod_reg;
                mul_a      = sx(ey_arr[cs_reg]);
                mul_b      = sx(dif(spt_reg.x, corner_x_reg[cs_reg]));
                state_next = ST_SIDE3;
            end
            ST_SIDE3: begin
                side_next  = t1_reg - prod_reg;
                state_next = side_ret_reg;
            end
            ST_P_DEC: begin
                fr_in_next[cs_reg] = side_in;
                if (!started_reg[cs_reg]) begin
                    started_next[cs_reg] = 1'b1;
                    first_next[cs_reg]   = fr_pt_reg[cs_reg];
                    state_next           = ST_P_EMC;
                end else if (side_in != prev_in_reg[cs_reg]) begin
                    ip_next          = prev_reg[cs_reg];
                    ic_next          = fr_pt_reg[cs_reg];
                    sc_next          = side_mag;
                    spt_next         = prev_reg[cs_reg];
                    side_ret_next    = ST_I_DEN;
                    ret_next[cs_reg] = RET_X;
                    state_next       = ST_SIDE1;
                end else begin
                    state_next = ST_P_EMC;
                end
            end
            ST_P_EMC: begin
                if (fr_in_reg[cs_reg]) begin
                    ev_next          = fr_pt_reg[cs_reg];
                    ret_next[cs_reg] = RET_C;
                    state_next       = ST_EMIT;
                end else begin
                    state_next = ST_P_END;
                end
            end
            ST_P_END: begin
                prev_next[cs_reg]    = fr_pt_reg[cs_reg];
                prev_in_next[cs_reg] = fr_in_reg[cs_reg];
                if (cs_reg == '0) begin
                    state_next = rlast_reg ? ST_C_START : ST_IDLE;
                end else begin
                    cs_next    = cs_reg - 1'b1;
                    state_next = ST_RESUME;
                end
            end
            ST_RESUME: begin
                case (ret_reg[cs_reg])
                    RET_X:   state_next = ST_P_EMC;
                    RET_C:   state_next = ST_P_END;
                    RET_CL:  state_next = ST_C_NEXT;
                    default: state_next = ST_C_NEXT;
                endcase
            end
            ST_I_DEN: begin
                sp_next    = side_mag;
                state_next = ST_I_DEN2;
            end
            ST_I_DEN2: begin
                den_next  = den_sum;
                axis_next = 1'b0;
                if (den_sum == '0) begin
                    ev_next    = ip_reg;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_I_M1;
                end
            end
            ST_I_M1: begin
                mul_a      = {1'b0, sp_reg[QUO_W-1:0]};
                mul_b      = {1'b0, dmag};
                state_next = ST_I_M2;
            end
            ST_I_M2: begin
                t1_next    = prod_reg;
                mul_a      = {1'b0, sp_reg[MAG_W-1:QUO_W]};
                mul_b      = {1'b0, dmag};
                state_next = ST_I_M3;
            end
            ST_I_M3: begin
                div_start  = 1'b1;
                state_next = ST_I_DIV;
            end
            ST_I_DIV: begin
                if (div_done) begin
                    if (!axis_reg) begin
                        ev_next.x  = lerp_res;
                        axis_next  = 1'b1;
                        state_next = ST_I_M1;
                    end else begin
                        ev_next.y  = lerp_res;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (cs_reg != LAST_STAGE) begin
                    fr_pt_next[cs_reg + 1'b1] = ev_reg;
                    cs_next                   = cs_reg + 1'b1;
                    state_next                = ST_PUSH;
                end else begin
                    state_next = ST_F1;
                end
            end
            ST_F1: begin
                if (fan_cnt_reg == 2'd0) begin
                    anc_next     = ev_reg;
                    fan_cnt_next = 2'd1;
                    state_next   = ST_RESUME;
                end else if (fan_cnt_reg == 2'd1) begin
                    fprev_next   = ev_reg;
                    fan_cnt_next = 2'd2;
                    state_next   = ST_RESUME;
                end else begin
                    mul_a      = sx(dif(fprev_reg.x, anc_reg.x));
                    mul_b      = sx(dif(ev_reg.y, anc_reg.y));
                    state_next = ST_F2;
                end
            end
            ST_F2: begin
                t1_next    = prod_reg;
                mul_a      = sx(dif(fprev_reg.y, anc_reg.y));
                mul_b      = sx(dif(ev_reg.x, anc_reg.x));
                state_next = ST_F3;
            end
            ST_F3: begin
                term_next  = t1_reg - prod_reg;
                state_next = ST_F4;
            end
            ST_F4: begin
                ring_acc_next = acc_sat;
                fprev_next    = ev_reg;
                state_next    = ST_RESUME;
            end
            ST_C_START: begin
                if (started_reg[cs_reg]) begin
                    spt_next      = first_reg[cs_reg];
                    side_ret_next = ST_C_DEC;
                    state_next    = ST_SIDE1;
                end else begin
                    state_next = ST_C_NEXT;
                end
            end
            ST_C_DEC: begin
                if (side_in != prev_in_reg[cs_reg]) begin
                    ip_next          = prev_reg[cs_reg];
                    ic_next          = first_reg[cs_reg];
                    sc_next          = side_mag;
                    spt_next         = prev_reg[cs_reg];
                    side_ret_next    = ST_I_DEN;
                    ret_next[cs_reg] = RET_CL;
                    state_next       = ST_SIDE1;
                end else begin
                    state_next = ST_C_NEXT;
                end
            end
            ST_C_NEXT: begin
                started_next[cs_reg] = 1'b0;
                if (cs_reg != LAST_STAGE) begin
                    cs_next    = cs_reg + 1'b1;
                    state_next = ST_C_START;
                end else begin
                    state_next = ST_FIN1;
                end
            end
            ST_FIN1: begin
                area_next  = hole_reg ? -half : half;
                state_next = ST_FIN2;
            end
            ST_FIN2: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.ring_area  = area_reg;
                    m_data_next.total_area = (!tsat[ACC_W-1] && tsat != '0)
                                           ? tsat[ACC_W-2:0] : '0;
                    m_data_next.set_done   = slast_reg;
                    m_valid_next           = 1'b1;
                    total_next             = slast_reg ? '0 : tsat;
                    started_next           = '0;
                    fan_cnt_next           = '0;
                    ring_acc_next          = '0;
                    cs_next                = '0;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cs_reg       <= '0;
            started_reg  <= '0;
            fan_cnt_reg  <= '0;
            ring_acc_reg <= '0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
            for (int s = 0; s < NUM_STAGES; s++) begin
                corner_x_reg[s] <= '0;
                corner_y_reg[s] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            cs_reg       <= cs_next;
            started_reg  <= started_next;
            fan_cnt_reg  <= fan_cnt_next;
            ring_acc_reg <= ring_acc_next;
            total_reg    <= total_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_CFG_REGS)) begin
                if (cfg_index[0]) begin
                    corner_y_reg[cfg_index[STAGE_W:1]] <= cfg_data;
                end else begin
                    corner_x_reg[cfg_index[STAGE_W:1]] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        side_ret_reg <= side_ret_next;
        fr_pt_reg    <= fr_pt_next;
        ret_reg      <= ret_next;
        first_reg    <= first_next;
        prev_reg     <= prev_next;
        fr_in_reg    <= fr_in_next;
        prev_in_reg  <= prev_in_next;
        spt_reg      <= spt_next;
        ip_reg       <= ip_next;
        ic_reg       <= ic_next;
        ev_reg       <= ev_next;
        anc_reg      <= anc_next;
        fprev_reg    <= fprev_next;
        area_reg     <= area_next;
        prod_reg     <= mul_a * mul_b;
        t1_reg       <= t1_next;
        side_reg     <= side_next;
        term_reg     <= term_next;
        sp_reg       <= sp_next;
        sc_reg       <= sc_next;
        den_reg      <= den_next;
        axis_reg     <= axis_next;
        hole_reg     <= hole_next;
        rlast_reg    <= rlast_next;
        slast_reg    <= slast_next;
        m_data_reg   <= m_data_next;
    end

    cqca_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (quo)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    a_idle_stage0: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> cs_reg == '0)
        else $error("idle with stage pointer away from stage zero");

    a_fan_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        fan_cnt_reg != 2'd3)
        else $error("fan vertex count out of range");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("still ready after taking a word");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_I_DIV)
        else $error("divider finished outside the wait state");

    a_ring_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN2 && state_next == ST_IDLE |=> m_valid_reg)
        else $error("ring end without a result word");

endmodule

[src/cqca_div.sv]
// restoring divider, one quotient bit per cycle
// depends on cqca_pkg; quotient must fit in QUO_W bits
module cqca_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cqca_pkg::div_req_t          req,
    output logic                        done,
    output logic [cqca_pkg::QUO_W-1:0]  quo
);
    import cqca_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [QUO_W-1:0] q_reg, q_next;
    logic [NUM_W:0]   trial;
    logic             ge;

    assign trial = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign ge    = ~trial[NUM_W];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (req.start) begin
            busy_next = 1'b1;
            rem_next  = req.num;
            dsh_next  = NUM_W'(req.den) << (QUO_W - 1);
            cnt_next  = CNT_W'(QUO_W - 1);
            q_next    = '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = trial[NUM_W-1:0];
            end
            q_next   = {q_reg[QUO_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule
